// File: design/ilid_pkg.sv
// Shared types and constants for the indexed list block.
package ilid_pkg;

    // Default sizing of the list store
    localparam int MAX_ENTRIES = 64;
    localparam int WORD_BITS   = 32;

    // Fixed field widths of the channels
    localparam int OPC_W   = 2;
    localparam int POS_W   = 7;
    localparam int XWORD_W = 32;
    localparam int CNT_W   = 7;
    localparam int ST_W    = 2;

    // Request codes; code 3 is unused and does nothing
    typedef enum logic [OPC_W-1:0] {
        OP_INSERT = 2'd0,
        OP_READ   = 2'd1,
        OP_DELETE = 2'd2
    } t_opcode;

    // Result status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_RD_WAIT,
        S_SH_RD,
        S_SH_WR,
        S_INS_PUT,
        S_DEL_END,
        S_DONE
    } t_state;

endpackage

// File: design/ilid_channels.sv
// Valid/ready channel interfaces for requests and results of the indexed list.
interface ilid_req_if;
    logic                         valid;
    logic                         ready;
    logic [ilid_pkg::OPC_W-1:0]   opcode;
    logic [ilid_pkg::POS_W-1:0]   position;
    logic [ilid_pkg::XWORD_W-1:0] item_word;

    modport source (output valid, opcode, position, item_word, input ready);
    modport sink   (input valid, opcode, position, item_word, output ready);
endinterface

interface ilid_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [ilid_pkg::ST_W-1:0]    status;
    logic [ilid_pkg::XWORD_W-1:0] read_word;
    logic [ilid_pkg::CNT_W-1:0]   item_count;

    modport source (output valid, status, read_word, item_count, input ready);
    modport sink   (input valid, status, read_word, item_count, output ready);
endinterface

// File: design/ilid_store.sv
// Single-port entry store with registered read data.
module ilid_store #(
    parameter int DEPTH  = ilid_pkg::MAX_ENTRIES,
    parameter int WIDTH  = ilid_pkg::WORD_BITS,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [WIDTH-1:0]  i_wdata,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One access per cycle: write, or read into the output register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/indexed_list_insert_delete.sv
// Indexed list: insert, read and delete by position over a single-port store.
// Sequence: a request is decided; refused and unused requests go straight to the
//   result, a read waits for the store, and an insert or delete shifts the entries
//   past the position (one read then one write each on the single memory port) and
//   then puts the new word or ends the delete. One request is taken at a time.
// Reset (synchronous): entry count and control clear; store contents are left as is.
module indexed_list_insert_delete #(
    parameter int MAX_ENTRIES = ilid_pkg::MAX_ENTRIES,
    parameter int WORD_BITS   = ilid_pkg::WORD_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ilid_req_if.sink   i_req,
    ilid_rsp_if.source o_rsp
);

    localparam int AW  = $clog2(MAX_ENTRIES);
    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int PW  = (CW > ilid_pkg::POS_W) ? CW : ilid_pkg::POS_W;

    ilid_pkg::t_state r_st, n_st;

    // Request and working registers
    logic [ilid_pkg::OPC_W-1:0]   r_op;
    logic [ilid_pkg::POS_W-1:0]   r_pos;
    logic [WORD_BITS-1:0]         r_word;
    logic [CW-1:0]                r_cnt;
    logic [CW-1:0]                r_idx;
    logic [ilid_pkg::ST_W-1:0]    r_status;
    logic [ilid_pkg::XWORD_W-1:0] r_rdata;

    // Result register
    logic                         r_out_valid;
    logic [ilid_pkg::ST_W-1:0]    r_out_status;
    logic [ilid_pkg::XWORD_W-1:0] r_out_word;
    logic [ilid_pkg::CNT_W-1:0]   r_out_count;

    // Memory port
    logic                 mem_en;
    logic                 mem_we;
    logic [AW-1:0]        mem_addr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [WORD_BITS-1:0] mem_rdata;

    logic          w_accept;
    logic          w_load;
    logic          w_is_ins;
    logic          w_is_rd;
    logic          w_is_del;
    logic [PW-1:0] w_pos;
    logic [PW-1:0] w_cnt;
    logic          w_empty;
    logic          w_full;
    logic          w_pos_gt;
    logic          w_pos_ge;
    logic          w_del_more;
    logic [CW-1:0] w_idx_step;
    logic          w_sh_more;

    assign w_accept = i_req.valid && i_req.ready;
    assign w_load   = (r_st == ilid_pkg::S_DONE) && (!r_out_valid || o_rsp.ready);

    // Position and count checks
    assign w_is_ins   = (r_op == ilid_pkg::OP_INSERT);
    assign w_is_rd    = (r_op == ilid_pkg::OP_READ);
    assign w_is_del   = (r_op == ilid_pkg::OP_DELETE);
    assign w_pos      = PW'(r_pos);
    assign w_cnt      = PW'(r_cnt);
    assign w_empty    = (r_cnt == '0);
    assign w_full     = (r_cnt == CW'(MAX_ENTRIES));
    assign w_pos_gt   = (w_pos > w_cnt);
    assign w_pos_ge   = (w_pos >= w_cnt);
    assign w_del_more = ((w_pos + PW'(1)) < w_cnt);

    // Shared index step: down for insert, up for delete
    assign w_idx_step = w_is_ins ? (r_idx - CW'(1)) : (r_idx + CW'(1));
    assign w_sh_more  = w_is_ins ? (PW'(w_idx_step) != w_pos)
                                 : ((PW'(w_idx_step) + PW'(1)) < w_cnt);

    // Next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ilid_pkg::S_IDLE: begin
                if (w_accept) n_st = ilid_pkg::S_DECIDE;
            end
            ilid_pkg::S_DECIDE: begin
                n_st = ilid_pkg::S_DONE;
                if (w_is_ins) begin
                    if (!w_pos_gt && !w_full) begin
                        n_st = (w_pos == w_cnt) ? ilid_pkg::S_INS_PUT : ilid_pkg::S_SH_RD;
                    end
                end else if (w_is_rd) begin
                    if (!w_empty && !w_pos_ge) n_st = ilid_pkg::S_RD_WAIT;
                end else if (w_is_del) begin
                    if (!w_empty && !w_pos_ge) begin
                        n_st = w_del_more ? ilid_pkg::S_SH_RD : ilid_pkg::S_DEL_END;
                    end
                end
            end
            ilid_pkg::S_RD_WAIT: n_st = ilid_pkg::S_DONE;
            ilid_pkg::S_SH_RD:   n_st = ilid_pkg::S_SH_WR;
            ilid_pkg::S_SH_WR: begin
                if (w_sh_more) begin
                    n_st = ilid_pkg::S_SH_RD;
                end else begin
                    n_st = w_is_ins ? ilid_pkg::S_INS_PUT : ilid_pkg::S_DEL_END;
                end
            end
            ilid_pkg::S_INS_PUT: n_st = ilid_pkg::S_DONE;
            ilid_pkg::S_DEL_END: n_st = ilid_pkg::S_DONE;
            ilid_pkg::S_DONE: begin
                if (w_load) n_st = ilid_pkg::S_IDLE;
            end
            default: n_st = ilid_pkg::S_IDLE;
        endcase
    end

    // Outputs of the sequencer: request ready and memory port
    always_comb begin
        i_req.ready = 1'b0;
        mem_en      = 1'b0;
        mem_we      = 1'b0;
        mem_addr    = r_idx[AW-1:0];
        mem_wdata   = mem_rdata;
        unique case (r_st)
            ilid_pkg::S_IDLE: i_req.ready = 1'b1;
            ilid_pkg::S_DECIDE: begin
                // read request issues its memory read right away
                if (w_is_rd && !w_empty && !w_pos_ge) begin
                    mem_en   = 1'b1;
                    mem_addr = w_pos[AW-1:0];
                end
            end
            ilid_pkg::S_SH_RD: begin
                mem_en   = 1'b1;
                mem_addr = w_idx_step[AW-1:0];
            end
            ilid_pkg::S_SH_WR: begin
                mem_en = 1'b1;
                mem_we = 1'b1;
            end
            ilid_pkg::S_INS_PUT: begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = w_pos[AW-1:0];
                mem_wdata = r_word;
            end
            ilid_pkg::S_RD_WAIT, ilid_pkg::S_DEL_END, ilid_pkg::S_DONE: ;
            default: ;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ilid_pkg::S_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    // Entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (r_st == ilid_pkg::S_INS_PUT) begin
            r_cnt <= r_cnt + CW'(1);
        end else if (r_st == ilid_pkg::S_DEL_END) begin
            r_cnt <= r_cnt - CW'(1);
        end
    end

    // Request capture, status, index and read data
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= i_req.opcode;
            r_pos  <= i_req.position;
            r_word <= WORD_BITS'(i_req.item_word);
        end
        if (r_st == ilid_pkg::S_DECIDE) begin
            r_rdata <= '0;
            r_idx   <= w_is_ins ? r_cnt : w_pos[CW-1:0];
            if (w_is_ins) begin
                if (w_pos_gt)    r_status <= ilid_pkg::ST_RANGE;
                else if (w_full) r_status <= ilid_pkg::ST_FULL;
                else             r_status <= ilid_pkg::ST_OK;
            end else if (w_is_rd || w_is_del) begin
                if (w_empty)       r_status <= ilid_pkg::ST_EMPTY;
                else if (w_pos_ge) r_status <= ilid_pkg::ST_RANGE;
                else               r_status <= ilid_pkg::ST_OK;
            end else begin
                r_status <= ilid_pkg::ST_OK;
            end
        end
        if (r_st == ilid_pkg::S_SH_WR) begin
            r_idx <= w_idx_step;
        end
        if (r_st == ilid_pkg::S_RD_WAIT) begin
            r_rdata <= ilid_pkg::XWORD_W'(mem_rdata);
        end
    end

    // Result register, free to take the next result once the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_status <= r_status;
            r_out_word   <= r_rdata;
            r_out_count  <= ilid_pkg::CNT_W'(r_cnt);
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.read_word  = r_out_word;
    assign o_rsp.item_count = r_out_count;

    ilid_store #(
        .DEPTH  (MAX_ENTRIES),
        .WIDTH  (WORD_BITS),
        .ADDR_W (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    // Count never exceeds capacity
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_ENTRIES))
        else $error("entry count above capacity");

    // Count moves only at the end of an insert or delete
    a_cnt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_st == ilid_pkg::S_INS_PUT || r_st == ilid_pkg::S_DEL_END) |=> $stable(r_cnt))
        else $error("entry count changed outside insert or delete");

    // A taken request always starts the decision step
    a_accept_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_st == ilid_pkg::S_DECIDE)
        else $error("accepted request did not enter decision step");

    // Nonzero read data only comes with an ok status
    a_word_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_word != '0) |-> r_out_status == ilid_pkg::ST_OK)
        else $error("read data returned with a refusal status");

    // Memory writes happen only in shift or insert steps
    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (mem_en && (r_st == ilid_pkg::S_SH_WR || r_st == ilid_pkg::S_INS_PUT)))
        else $error("memory write outside shift or insert");

endmodule

// File: dv/indexed_list_checker.sv
// Checker for the indexed list: predicts each result from accepted requests and compares.
`timescale 1ns / 1ps

module indexed_list_checker #(
    parameter int MAX_ENTRIES = ilid_pkg::MAX_ENTRIES,
    parameter int WORD_BITS   = ilid_pkg::WORD_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ilid_req_if  i_req_mon,
    ilid_rsp_if  i_rsp_mon,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_entries,
    output int   o_checked,
    output int   o_full_hits,
    output int   o_empty_hits,
    output int   o_range_hits,
    output int   o_peak_entries
);

    // One predicted result beat
    typedef struct packed {
        ilid_pkg::t_status                  status;
        logic [ilid_pkg::XWORD_W-1:0]       read_word;
        logic [ilid_pkg::CNT_W-1:0]         item_count;
    } t_list_result;

    // Shadow copy of the list contents and length
    logic [WORD_BITS-1:0] shadow_words [MAX_ENTRIES];
    int                   shadow_len;

    t_list_result pending_results [$];
    t_list_result oldest;

    int fail_count;
    int checked;
    int full_hits;
    int empty_hits;
    int range_hits;
    int peak_len;

    // Apply one request to the shadow list and return the result it must give
    function automatic t_list_result apply_list_request(
        logic [ilid_pkg::OPC_W-1:0]   opc,
        logic [ilid_pkg::POS_W-1:0]   pos,
        logic [ilid_pkg::XWORD_W-1:0] word);
        t_list_result res;
        int           p;
        int           k;
        res.status    = ilid_pkg::ST_OK;
        res.read_word = '0;
        p             = int'(pos);
        unique case (opc)
            ilid_pkg::OP_INSERT: begin
                // range is checked before fullness
                if (p > shadow_len) begin
                    res.status = ilid_pkg::ST_RANGE;
                end else if (shadow_len >= MAX_ENTRIES) begin
                    res.status = ilid_pkg::ST_FULL;
                end else begin
                    for (k = shadow_len; k > p; k--)
                        shadow_words[k] = shadow_words[k-1];
                    shadow_words[p] = word[WORD_BITS-1:0];
                    shadow_len++;
                end
            end
            ilid_pkg::OP_READ: begin
                if (shadow_len == 0)
                    res.status = ilid_pkg::ST_EMPTY;
                else if (p >= shadow_len)
                    res.status = ilid_pkg::ST_RANGE;
                else
                    res.read_word = ilid_pkg::XWORD_W'(shadow_words[p]);
            end
            ilid_pkg::OP_DELETE: begin
                if (shadow_len == 0) begin
                    res.status = ilid_pkg::ST_EMPTY;
                end else if (p >= shadow_len) begin
                    res.status = ilid_pkg::ST_RANGE;
                end else begin
                    for (k = p; k + 1 < shadow_len; k++)
                        shadow_words[k] = shadow_words[k+1];
                    shadow_len--;
                end
            end
            default: ;  // unused code: no change, status ok
        endcase
        res.item_count = ilid_pkg::CNT_W'(shadow_len);
        return res;
    endfunction

    // Compare one field of a result beat
    task automatic check_field(string name, logic [ilid_pkg::XWORD_W-1:0] exp_val,
                               logic [ilid_pkg::XWORD_W-1:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s: expected %0h, got %0h", name, exp_val, act_val);
            fail_count++;
        end
    endtask

    // Result beats are checked before the request of the same edge is predicted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_len = 0;
            pending_results.delete();
            fail_count = 0;
            checked    = 0;
            full_hits  = 0;
            empty_hits = 0;
            range_hits = 0;
            peak_len   = 0;
        end else begin
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                if (pending_results.size() == 0) begin
                    $error("result beat with no request outstanding");
                    fail_count++;
                end else begin
                    oldest = pending_results.pop_front();
                    check_field("status", ilid_pkg::XWORD_W'(oldest.status),
                                ilid_pkg::XWORD_W'(i_rsp_mon.status));
                    check_field("read_word", oldest.read_word, i_rsp_mon.read_word);
                    check_field("item_count", ilid_pkg::XWORD_W'(oldest.item_count),
                                ilid_pkg::XWORD_W'(i_rsp_mon.item_count));
                    checked++;
                    unique case (oldest.status)
                        ilid_pkg::ST_FULL:  full_hits++;
                        ilid_pkg::ST_EMPTY: empty_hits++;
                        ilid_pkg::ST_RANGE: range_hits++;
                        default:            ;
                    endcase
                end
            end
            if (i_req_mon.valid && i_req_mon.ready) begin
                pending_results.push_back(apply_list_request(i_req_mon.opcode,
                                                             i_req_mon.position,
                                                             i_req_mon.item_word));
                if (shadow_len > peak_len)
                    peak_len = shadow_len;
            end
        end
        o_fail_count   <= fail_count;
        o_pending      <= pending_results.size();
        o_entries      <= shadow_len;
        o_checked      <= checked;
        o_full_hits    <= full_hits;
        o_empty_hits   <= empty_hits;
        o_range_hits   <= range_hits;
        o_peak_entries <= peak_len;
    end

endmodule

// File: dv/indexed_list_insert_delete_tb.sv
// Testbench top for the indexed list: clock, reset, request and result traffic, verdict.
`timescale 1ns / 1ps

module indexed_list_insert_delete_tb;

    localparam logic [ilid_pkg::OPC_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1080;
    localparam int HOLD_CYCLES  = 400;

    // Traffic shapes of the random part
    localparam int MODE_FILL  = 0;
    localparam int MODE_MIXED = 1;
    localparam int MODE_DRAIN = 2;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ilid_req_if req_ch ();
    ilid_rsp_if rsp_ch ();

    int fail_count, pending, live_entries, checked;
    int full_hits, empty_hits, range_hits, peak_entries;

    // Sender burst state and request tallies
    int burst_left;
    int n_insert, n_read, n_delete, n_unused;
    bit hold_wanted;
    bit hold_done;

    always #2 i_clk = ~i_clk;

    indexed_list_insert_delete dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    indexed_list_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_mon      (req_ch),
        .i_rsp_mon      (rsp_ch),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_entries      (live_entries),
        .o_checked      (checked),
        .o_full_hits    (full_hits),
        .o_empty_hits   (empty_hits),
        .o_range_hits   (range_hits),
        .o_peak_entries (peak_entries)
    );

    // Offer one request beat; valid stays up inside a burst
    task automatic drive_item(logic [ilid_pkg::OPC_W-1:0] opc,
                              logic [ilid_pkg::POS_W-1:0] pos,
                              logic [ilid_pkg::XWORD_W-1:0] word);
        int gap;
        req_ch.valid     <= 1'b1;
        req_ch.opcode    <= opc;
        req_ch.position  <= pos;
        req_ch.item_word <= word;
        do @(posedge i_clk); while (!req_ch.ready);
        unique case (opc)
            ilid_pkg::OP_INSERT: n_insert++;
            ilid_pkg::OP_READ:   n_read++;
            ilid_pkg::OP_DELETE: n_delete++;
            default:             n_unused++;
        endcase
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Result side: segments of differing stall density, plus one long hold-off
    initial begin
        int seg_left;
        int seg_mode;
        int hold_left;
        seg_left  = 0;
        seg_mode  = 0;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                rsp_ch.ready <= 1'b0;
            end else if (hold_wanted && !hold_done) begin
                rsp_ch.ready <= 1'b0;
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end else if (hold_left > 0) begin
                hold_left--;
            end else begin
                if (seg_left == 0) begin
                    seg_mode = $urandom_range(0, 3);
                    seg_left = $urandom_range(10, 120);
                end
                seg_left--;
                unique case (seg_mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= $urandom_range(0, 1);
                    2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Run limit
    initial begin
        #8_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Stimulus and verdict
    initial begin
        int mode;
        int phase_left;
        int r;
        int len;
        logic [ilid_pkg::OPC_W-1:0] opc;
        logic [ilid_pkg::POS_W-1:0] pos;

        burst_left  = 1;
        hold_wanted = 1'b0;
        hold_done   = 1'b0;
        n_insert = 0;
        n_read   = 0;
        n_delete = 0;
        n_unused = 0;

        i_rst_n          <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.opcode    <= ilid_pkg::OP_INSERT;
        req_ch.position  <= '0;
        req_ch.item_word <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty list refusals, insert at front, middle and end
        drive_item(ilid_pkg::OP_READ,   7'd0,   32'h0);
        drive_item(ilid_pkg::OP_DELETE, 7'd0,   32'h0);
        drive_item(ilid_pkg::OP_INSERT, 7'd1,   32'h1234_5678);
        drive_item(ilid_pkg::OP_INSERT, 7'd0,   32'h0000_0000);
        drive_item(ilid_pkg::OP_INSERT, 7'd1,   32'hFFFF_FFFF);
        drive_item(ilid_pkg::OP_INSERT, 7'd0,   32'hA5A5_A5A5);
        drive_item(ilid_pkg::OP_INSERT, 7'd1,   32'h5A5A_5A5A);
        drive_item(ilid_pkg::OP_READ,   7'd0,   32'hFFFF_FFFF);
        drive_item(ilid_pkg::OP_READ,   7'd1,   32'h0);
        drive_item(ilid_pkg::OP_READ,   7'd2,   32'h0);
        drive_item(ilid_pkg::OP_READ,   7'd3,   32'h0);
        drive_item(ilid_pkg::OP_READ,   7'd4,   32'h0);
        drive_item(ilid_pkg::OP_READ,   7'd127, 32'h0);
        drive_item(OP_UNUSED,           7'd127, 32'hFFFF_FFFF);
        drive_item(ilid_pkg::OP_INSERT, 7'd127, 32'hDEAD_BEEF);
        drive_item(ilid_pkg::OP_DELETE, 7'd4,   32'h0);
        drive_item(ilid_pkg::OP_DELETE, 7'd127, 32'h0);
        drive_item(ilid_pkg::OP_DELETE, 7'd1,   32'h0);
        drive_item(ilid_pkg::OP_DELETE, 7'd2,   32'h0);
        drive_item(ilid_pkg::OP_DELETE, 7'd0,   32'h0);
        drive_item(ilid_pkg::OP_READ,   7'd0,   32'h0);
        drive_item(ilid_pkg::OP_DELETE, 7'd0,   32'h0);
        drive_item(ilid_pkg::OP_DELETE, 7'd0,   32'h0);

        // Random: phases that fill to capacity, churn and drain to empty
        mode       = MODE_FILL;
        phase_left = $urandom_range(90, 160);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                mode       = (mode + 1) % 3;
                phase_left = $urandom_range(60, 160);
            end
            phase_left--;
            if (n == 300) hold_wanted = 1'b1;

            r = $urandom_range(0, 99);
            unique case (mode)
                MODE_FILL:  opc = (r < 70) ? ilid_pkg::OP_INSERT :
                                  (r < 85) ? ilid_pkg::OP_READ :
                                  (r < 97) ? ilid_pkg::OP_DELETE : OP_UNUSED;
                MODE_DRAIN: opc = (r < 15) ? ilid_pkg::OP_INSERT :
                                  (r < 30) ? ilid_pkg::OP_READ :
                                  (r < 97) ? ilid_pkg::OP_DELETE : OP_UNUSED;
                MODE_MIXED: opc = (r < 35) ? ilid_pkg::OP_INSERT :
                                  (r < 65) ? ilid_pkg::OP_READ :
                                  (r < 97) ? ilid_pkg::OP_DELETE : OP_UNUSED;
                default:    opc = OP_UNUSED;
            endcase

            // mostly legal positions, some on the boundary, some anywhere
            len = live_entries;
            r   = $urandom_range(0, 99);
            if (r < 80) begin
                if (opc == ilid_pkg::OP_INSERT)
                    pos = ilid_pkg::POS_W'($urandom_range(0, len));
                else
                    pos = (len == 0) ? '0 : ilid_pkg::POS_W'($urandom_range(0, len - 1));
            end else if (r < 90) begin
                pos = ilid_pkg::POS_W'(len);
            end else begin
                pos = ilid_pkg::POS_W'($urandom_range(0, 127));
            end

            drive_item(opc, pos, $urandom);
        end
        req_ch.valid <= 1'b0;

        // The checker's count outputs are registered, so they lag the last beat
        @(posedge i_clk);
        // Drain outstanding results, then allow the block to settle
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Sent %0d inserts, %0d reads, %0d deletes and %0d unused-code requests.",
                 n_insert, n_read, n_delete, n_unused);
        $display("Checked %0d results: %0d full, %0d empty, %0d range refusals; depth peak %0d.",
                 checked, full_hits, empty_hits, range_hits, peak_entries);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
